FILE: rtl/cbd_pkg.sv
// ----------------------------------------------------------------------------
// Chunked body decoder package
// Shared types, codes and default sizes for the chunked body decoder.
// ----------------------------------------------------------------------------
package cbd_pkg;

  localparam int LINE_COUNT_BITS_DEF = 12;
  localparam int SIZE_BITS_DEF       = 32;
  localparam int CFG_W               = 12;
  localparam logic [CFG_W-1:0] MAX_LINE_LEN_RST = 12'd2048;

  localparam logic [7:0] CH_CR   = 8'h0D;
  localparam logic [7:0] CH_LF   = 8'h0A;

  localparam logic [1:0] ST_MORE = 2'd0;
  localparam logic [1:0] ST_DONE = 2'd1;
  localparam logic [1:0] ST_BAD  = 2'd2;

  typedef enum logic [3:0] {
    PH_DIGITS  = 4'd0,
    PH_SKIP    = 4'd1,
    PH_LINE_CR = 4'd2,
    PH_DATA    = 4'd3,
    PH_DATA_CR = 4'd4,
    PH_DATA_LF = 4'd5,
    PH_TERM    = 4'd6,
    PH_DONE    = 4'd7
  } phase_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       first_byte;
    logic       buffer_end;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] size_total;
    logic [31:0] consumed_bytes;
  } out_item_t;

endpackage

FILE: rtl/cbd_parser.sv
// ----------------------------------------------------------------------------
// Chunked body parser
// Holds the parse state and updates it by one body byte per step.
// ----------------------------------------------------------------------------
module cbd_parser #(
  parameter int LINE_COUNT_BITS = cbd_pkg::LINE_COUNT_BITS_DEF,
  parameter int SIZE_BITS       = cbd_pkg::SIZE_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            step,
  input  cbd_pkg::in_item_t               item,
  input  logic [cbd_pkg::CFG_W-1:0]       max_line_len,
  output logic                            res_valid,
  output cbd_pkg::out_item_t              res
);
  import cbd_pkg::*;

  localparam int SUM_W = ((SIZE_BITS > 32) ? SIZE_BITS : 32) + 1;

  phase_t                     phase_r, phase_nxt;
  logic [SIZE_BITS-1:0]       chunk_r, chunk_nxt;
  logic [SIZE_BITS-1:0]       left_r, left_nxt;
  logic [31:0]                total_r, total_nxt;
  logic [LINE_COUNT_BITS-1:0] line_r, line_nxt;
  logic [31:0]                count_r, count_nxt;
  logic [1:0]                 skip_r, skip_nxt;

  logic [LINE_COUNT_BITS-1:0] lim;
  logic [SUM_W-1:0]           sum;
  logic                       is_hex;
  logic [3:0]                 hex_val;
  logic [7:0]                 c;
  logic [1:0]                 st;

  assign c   = item.data_byte;
  assign lim = LINE_COUNT_BITS'(max_line_len);

  always_comb begin
    is_hex  = 1'b1;
    hex_val = 4'd0;
    if (c >= "0" && c <= "9") begin
      hex_val = 4'(c - "0");
    end else if (c >= "a" && c <= "f") begin
      hex_val = 4'(c - "a" + 8'd10);
    end else if (c >= "A" && c <= "F") begin
      hex_val = 4'(c - "A" + 8'd10);
    end else begin
      is_hex = 1'b0;
    end
  end

  always_comb begin
    phase_nxt = phase_r;
    chunk_nxt = chunk_r;
    left_nxt  = left_r;
    total_nxt = total_r;
    line_nxt  = line_r;
    count_nxt = count_r;
    skip_nxt  = skip_r;
    st        = ST_MORE;
    res_valid = 1'b0;
    if (item.first_byte) begin
      phase_nxt = PH_DIGITS;
      chunk_nxt = '0;
      left_nxt  = '0;
      total_nxt = '0;
      line_nxt  = '0;
      count_nxt = '0;
      skip_nxt  = '0;
    end
    sum = SUM_W'(chunk_nxt) + SUM_W'(total_nxt);
    if (phase_nxt != PH_DONE) begin
      if (count_nxt != 32'hFFFF_FFFF) begin
        count_nxt = count_nxt + 32'd1;
      end
      case (phase_nxt)
        PH_DIGITS, PH_SKIP, PH_LINE_CR: begin
          if (line_nxt >= lim) begin
            st = ST_BAD;
          end else begin
            line_nxt = line_nxt + LINE_COUNT_BITS'(1);
            if (phase_nxt == PH_LINE_CR && c == CH_LF) begin
              line_nxt = '0;
              if (chunk_nxt == '0) begin
                phase_nxt = PH_TERM;
                skip_nxt  = '0;
              end else begin
                left_nxt  = chunk_nxt;
                phase_nxt = PH_DATA;
              end
            end else if (c == CH_CR) begin
              phase_nxt = PH_LINE_CR;
            end else if (phase_nxt == PH_DIGITS && is_hex) begin
              if (chunk_nxt[SIZE_BITS-1 -: 4] != 4'd0) begin
                st = ST_BAD;
              end else begin
                chunk_nxt = {chunk_nxt[SIZE_BITS-5:0], hex_val};
              end
            end else begin
              phase_nxt = PH_SKIP;
            end
          end
        end
        PH_DATA: begin
          left_nxt = left_nxt - SIZE_BITS'(1);
          if (left_nxt == '0) begin
            phase_nxt = PH_DATA_CR;
          end
        end
        PH_DATA_CR: begin
          if (c != CH_CR) begin
            st = ST_BAD;
          end else begin
            phase_nxt = PH_DATA_LF;
          end
        end
        PH_DATA_LF: begin
          if (c != CH_LF || sum[SUM_W-1:32] != '0) begin
            st = ST_BAD;
          end else begin
            total_nxt = sum[31:0];
            chunk_nxt = '0;
            line_nxt  = '0;
            phase_nxt = PH_DIGITS;
          end
        end
        PH_TERM: begin
          skip_nxt = skip_nxt + 2'd1;
          if (skip_nxt >= 2'd2) begin
            st = ST_DONE;
          end
        end
        default: begin
        end
      endcase
      if (st != ST_MORE) begin
        phase_nxt = PH_DONE;
        res_valid = 1'b1;
      end else if (item.buffer_end) begin
        res_valid = 1'b1;
      end
    end
    res.status         = st;
    res.size_total     = total_nxt;
    res.consumed_bytes = (st == ST_DONE) ? count_nxt : 32'd0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_DIGITS;
      chunk_r <= '0;
      left_r  <= '0;
      total_r <= '0;
      line_r  <= '0;
      count_r <= '0;
      skip_r  <= '0;
    end else if (step) begin
      phase_r <= phase_nxt;
      chunk_r <= chunk_nxt;
      left_r  <= left_nxt;
      total_r <= total_nxt;
      line_r  <= line_nxt;
      count_r <= count_nxt;
      skip_r  <= skip_nxt;
    end
  end

endmodule

FILE: rtl/chunked_body_decoder_core.sv
// ----------------------------------------------------------------------------
// Chunked body decoder core
// Decodes an HTTP chunked body one byte per transfer and reports the result.
// ----------------------------------------------------------------------------
// The input channel takes one body byte per transfer, with flags that start a
// new body and mark the last byte currently buffered. The result channel
// gives one item when the body completes, when it is found invalid, or at
// buffer end, where the status reads needs-more-data. Most bytes give no
// result. The configuration port writes the longest allowed size line.
// A byte is held in an input register and is parsed from there into the
// result register once the result side can take it. One byte is taken
// every cycle while the result side keeps up; the input register and the
// result register let a new byte in while a result waits. When the receiver
// stalls with a result pending, the input register fills and ready drops
// until that result is taken. Reset clears the parse state, empties both
// registers and sets the line limit to 2048. After completion or invalid,
// bytes are dropped without a result until one with first_byte set starts a
// new body.
// ----------------------------------------------------------------------------
module chunked_body_decoder_core #(
  parameter int LINE_COUNT_BITS = cbd_pkg::LINE_COUNT_BITS_DEF,
  parameter int SIZE_BITS       = cbd_pkg::SIZE_BITS_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  cbd_pkg::in_item_t         in_item,
  output logic                      out_valid,
  input  logic                      out_ready,
  output cbd_pkg::out_item_t        out_item,
  input  logic                      cfg_we,
  input  logic [cbd_pkg::CFG_W-1:0] cfg_wdata
);
  import cbd_pkg::*;

  logic [CFG_W-1:0] max_line_len_r;
  logic             in_valid_r;
  in_item_t         in_item_r;
  logic             out_valid_r;
  out_item_t        out_item_r;
  logic             adv;
  logic             step;
  logic             res_valid;
  out_item_t        res;

  assign adv       = !out_valid_r || out_ready;
  assign step      = in_valid_r && adv;
  assign in_ready  = !in_valid_r || adv;
  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  cbd_parser #(
    .LINE_COUNT_BITS(LINE_COUNT_BITS),
    .SIZE_BITS      (SIZE_BITS)
  ) u_parser (
    .clk         (clk),
    .rst_n       (rst_n),
    .step        (step),
    .item        (in_item_r),
    .max_line_len(max_line_len_r),
    .res_valid   (res_valid),
    .res         (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_line_len_r <= MAX_LINE_LEN_RST;
      in_valid_r     <= 1'b0;
      out_valid_r    <= 1'b0;
    end else begin
      if (cfg_we) begin
        max_line_len_r <= cfg_wdata;
      end
      if (in_ready) begin
        in_valid_r <= in_valid;
      end
      if (adv) begin
        out_valid_r <= step && res_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      in_item_r <= in_item;
    end
    if (step && res_valid) begin
      out_item_r <= res;
    end
  end

endmodule

FILE: sim/chunked_body_decoder_core_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Chunked body decoder core testbench
// Streams chunked bodies through the decoder under random flow control and
// checks every result against a cycle-free model of the parse kept here.
// ----------------------------------------------------------------------------
module chunked_body_decoder_core_tb;
  import cbd_pkg::*;

  localparam int IDLE_LIMIT = 2000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  in_item_t in_item = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_item_t out_item;
  logic cfg_we = 1'b0;
  logic [CFG_W-1:0] cfg_wdata = '0;

  phase_t ph;
  logic [31:0] chunk_len;
  logic [31:0] left_len;
  logic [31:0] body_total;
  logic [11:0] line_len;
  logic [31:0] byte_total;
  logic [1:0] term_cnt;
  logic [11:0] line_limit;

  out_item_t expected_reports[$];
  out_item_t want;
  int errors = 0;
  int idle_cycles = 0;
  int sent_cnt = 0;
  int rx_hold = 0;
  bit tx_gaps_on = 1'b1;
  bit rx_stalls_on = 1'b1;

  chunked_body_decoder_core DUT (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_item(in_item),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_item(out_item),
    .cfg_we(cfg_we),
    .cfg_wdata(cfg_wdata)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  function automatic void clear_body();
    ph = PH_DIGITS;
    chunk_len = '0;
    left_len = '0;
    body_total = '0;
    line_len = '0;
    byte_total = '0;
    term_cnt = '0;
  endfunction

  function automatic bit decode_byte(input in_item_t it, output out_item_t rep);
    logic [1:0] st;
    logic [7:0] b;
    int nib;
    rep = '0;
    st = ST_MORE;
    b = it.data_byte;
    if (it.first_byte) clear_body();
    if (ph == PH_DONE) return 1'b0;
    if (byte_total != 32'hFFFF_FFFF) byte_total++;
    if (b >= "0" && b <= "9") nib = int'(b - "0");
    else if (b >= "a" && b <= "f") nib = int'(b - "a") + 10;
    else if (b >= "A" && b <= "F") nib = int'(b - "A") + 10;
    else nib = -1;
    if (ph inside {PH_DIGITS, PH_SKIP, PH_LINE_CR}) begin
      if (line_len >= line_limit) begin
        st = ST_BAD;
      end else begin
        line_len++;
        if (ph == PH_LINE_CR && b == CH_LF) begin
          line_len = '0;
          if (chunk_len == 0) begin
            ph = PH_TERM;
            term_cnt = '0;
          end else begin
            left_len = chunk_len;
            ph = PH_DATA;
          end
        end else if (b == CH_CR) begin
          ph = PH_LINE_CR;
        end else if (ph == PH_DIGITS && nib >= 0) begin
          if (chunk_len > 32'h0FFF_FFFF) st = ST_BAD;
          else chunk_len = {chunk_len[27:0], nib[3:0]};
        end else begin
          ph = PH_SKIP;
        end
      end
    end else begin
      case (ph)
        PH_DATA: begin
          left_len--;
          if (left_len == 0) ph = PH_DATA_CR;
        end
        PH_DATA_CR: begin
          if (b != CH_CR) st = ST_BAD;
          else ph = PH_DATA_LF;
        end
        PH_DATA_LF: begin
          if (b != CH_LF) begin
            st = ST_BAD;
          end else if (chunk_len > 32'hFFFF_FFFF - body_total) begin
            st = ST_BAD;
          end else begin
            body_total += chunk_len;
            chunk_len = '0;
            line_len = '0;
            ph = PH_DIGITS;
          end
        end
        PH_TERM: begin
          term_cnt++;
          if (term_cnt >= 2) st = ST_DONE;
        end
        default: ;
      endcase
    end
    if (st != ST_MORE) ph = PH_DONE;
    else if (!it.buffer_end) return 1'b0;
    rep.status = st;
    rep.size_total = body_total;
    rep.consumed_bytes = (st == ST_DONE) ? byte_total : 32'd0;
    return 1'b1;
  endfunction

  task automatic send_byte(input logic [7:0] b, input bit first, input bit last);
    in_item_t it;
    out_item_t rep;
    int gap;
    it.data_byte = b;
    it.first_byte = first;
    it.buffer_end = last;
    gap = tx_gaps_on ? $urandom_range(0, 3) : 0;
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_item <= it;
    do @(posedge clk); while (!in_ready);
    sent_cnt++;
    if (decode_byte(it, rep)) expected_reports.push_back(rep);
  endtask

  task automatic send_text(input string s, input bit first, input bit last_end);
    for (int i = 0; i < s.len(); i++) begin
      send_byte(s[i], first && i == 0, last_end && i == s.len() - 1);
    end
  endtask

  task automatic wait_idle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (expected_reports.size() != 0) @(posedge clk);
  endtask

  task automatic write_limit(input logic [CFG_W-1:0] v);
    wait_idle();
    repeat (4) @(posedge clk);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(negedge clk);
    cfg_we <= 1'b0;
    line_limit = v;
  endtask

  function automatic void add_size_line(ref logic [7:0] q[$], input int sz);
    string s;
    logic [7:0] c;
    s = $sformatf("%0h", sz);
    if ($urandom_range(0, 3) == 0) s = {"0", s};
    if (sz == 0 && $urandom_range(0, 3) == 0) s = "";
    for (int i = 0; i < s.len(); i++) begin
      c = s[i];
      if (c >= "a" && c <= "f" && $urandom_range(0, 1) == 1) c = c - 8'h20;
      q.push_back(c);
    end
    if ($urandom_range(0, 2) == 0) begin
      q.push_back(";");
      repeat ($urandom_range(0, 6)) begin
        c = 8'($urandom_range(0, 255));
        q.push_back((c == CH_CR) ? 8'h3B : c);
      end
    end
    q.push_back(CH_CR);
    q.push_back(CH_LF);
  endfunction

  // A body with one data chunk, an extension and an empty last size line;
  // buffer end falls inside the terminator, and a byte after the end is dropped.
  task automatic test_complete_body();
    send_text("1;\015\012", 1'b1, 1'b0);
    send_byte(8'hFF, 1'b0, 1'b0);
    send_text("\015\012\015\012x", 1'b0, 1'b1);
    send_byte(8'h00, 1'b0, 1'b1);
    send_byte("Z", 1'b0, 1'b1);
  endtask

  task automatic test_missing_crlf();
    send_text("1\015\012ZQ", 1'b1, 1'b0);
  endtask

  task automatic test_size_overflow();
    send_text("fFFFFFFFF", 1'b1, 1'b0);
  endtask

  // The result side holds off while the first nine bytes each ask for a result
  // (later bytes are dropped), so the decoder fills up and stops taking transfers.
  task automatic test_backpressure();
    wait_idle();
    tx_gaps_on = 1'b0;
    rx_stalls_on = 1'b0;
    rx_hold = 60;
    send_byte("3", 1'b1, 1'b1);
    repeat (29) send_byte("e", 1'b0, 1'b1);
    wait_idle();
    tx_gaps_on = 1'b1;
    rx_stalls_on = 1'b1;
  endtask

  task automatic test_line_limit();
    write_limit(12'd1);
    send_text("0\015", 1'b1, 1'b0);
    write_limit(12'd0);
    send_text("0", 1'b1, 1'b0);
  endtask

  task automatic test_random_bodies(input int n_items, input logic [CFG_W-1:0] lim,
                                    input bit gaps);
    logic [7:0] body[$];
    int stop;
    int sz;
    write_limit(lim);
    tx_gaps_on = gaps;
    rx_stalls_on = gaps;
    stop = sent_cnt + n_items;
    while (sent_cnt < stop) begin
      body.delete();
      if ($urandom_range(0, 9) == 0) begin
        repeat ($urandom_range(1, 20)) body.push_back(8'($urandom_range(0, 255)));
      end else begin
        repeat ($urandom_range(0, 3)) begin
          sz = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 300) : $urandom_range(1, 12);
          add_size_line(body, sz);
          repeat (sz) body.push_back(8'($urandom_range(0, 255)));
          body.push_back(CH_CR);
          body.push_back(CH_LF);
        end
        add_size_line(body, 0);
        repeat (2) body.push_back(8'($urandom_range(0, 255)));
        if ($urandom_range(0, 4) == 0) begin
          body[$urandom_range(0, body.size() - 1)] = 8'($urandom_range(0, 255));
        end
        if ($urandom_range(0, 9) == 0) body = body[0:$urandom_range(0, body.size() - 1)];
      end
      foreach (body[i]) begin
        send_byte(body[i],
                  (i == 0) ? ($urandom_range(0, 19) != 0) : ($urandom_range(0, 99) == 0),
                  $urandom_range(0, 9) == 0);
      end
      if ($urandom_range(0, 7) == 0) wait_idle();
    end
  endtask

  initial begin : result_sink
    int stall;
    forever begin
      @(negedge clk);
      stall = rx_stalls_on ? $urandom_range(0, 3) : 0;
      if (rx_hold > 0) begin
        stall = rx_hold;
        rx_hold = 0;
      end
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (expected_reports.size() == 0) begin
        $display("%0t: unexpected result: expected none, actual %p", $time, out_item);
        errors++;
      end else begin
        want = expected_reports.pop_front();
        if (out_item.status !== want.status) begin
          $display("%0t: status expected %0d actual %0d", $time, want.status,
                   out_item.status);
          errors++;
        end
        if (out_item.size_total !== want.size_total) begin
          $display("%0t: size_total expected %0d actual %0d", $time, want.size_total,
                   out_item.size_total);
          errors++;
        end
        if (out_item.consumed_bytes !== want.consumed_bytes) begin
          $display("%0t: consumed_bytes expected %0d actual %0d", $time,
                   want.consumed_bytes, out_item.consumed_bytes);
          errors++;
        end
      end
    end
    if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("%0t: no transfer for %0d cycles", $time, IDLE_LIMIT);
      $display("chunked_body_decoder_core_tb: errors");
      $finish;
    end
  end

  initial begin
    line_limit = MAX_LINE_LEN_RST;
    clear_body();
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    test_complete_body();
    test_missing_crlf();
    test_size_overflow();
    test_backpressure();
    test_line_limit();
    test_random_bodies(340, 12'd2048, 1'b1);
    test_random_bodies(170, 12'd4095, 1'b0);
    test_random_bodies(210, 12'($urandom_range(3, 8)), 1'b1);
    test_random_bodies(40, 12'd1, 1'b1);
    test_random_bodies(170, 12'($urandom_range(1, 4095)), 1'b1);
    wait_idle();
    repeat (10) @(posedge clk);
    if (errors == 0) begin
      $display("chunked_body_decoder_core_tb: clean");
    end else begin
      $display("chunked_body_decoder_core_tb: errors");
    end
    $finish;
  end

endmodule
